// File: rtl/core/gcte_pkg.sv
`default_nettype none

package gcte_pkg;

  // Angle format at the ports and CORDIC depth.
  localparam int ANGLE_FRAC_BITS = 16;
  localparam int CORDIC_ITERS    = 24;

  // Beat widths on the two streams.
  localparam int IN_W  = 152;
  localparam int OUT_W = 40;

  // CORDIC datapath width, reduced angle width, folded magnitude width.
  localparam int CW = 34;
  localparam int RW = 27;
  localparam int MW = 24;
  localparam int ZW = 31;

  localparam logic signed [RW-1:0] FULL_DEG  = RW'(360 << ANGLE_FRAC_BITS);
  localparam logic signed [RW-1:0] HALF_DEG  = RW'(180 << ANGLE_FRAC_BITS);
  localparam logic [MW-1:0]        HALF_MAG  = MW'(180 << ANGLE_FRAC_BITS);
  localparam logic [MW-1:0]        QUART_MAG = MW'(90 << ANGLE_FRAC_BITS);
  localparam logic [26:0]          DEG2RAD_Q32 = 27'd74961321;
  localparam int                   RAD_SHIFT = ANGLE_FRAC_BITS + 2;

  localparam logic signed [CW-1:0] GAIN_Q30    = CW'(652032874);
  localparam logic signed [CW-1:0] HALF_PI_Q30 = CW'(1686629713);

  // Square root and population division.
  localparam int          SQRT_BITS = 31;
  localparam int          NUM_W     = 40;
  localparam int          POP_SHIFT = 8;
  localparam int          DIV_BITS  = 17;
  localparam logic [40:0] DIV_D     = 41'd9765625;

  // Queue between front and back.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  // Register select (paddr bit 2) and reset values.
  localparam logic        REG_MIN_DIST = 1'b0;
  localparam logic        REG_RADIUS   = 1'b1;
  localparam logic [13:0] MIN_DIST_RST = 14'd100;
  localparam logic [15:0] RADIUS_RST   = 16'd3963;

  // One classified item handed from the front to the back.
  typedef struct packed {
    logic [ZW-1:0]    za;
    logic [ZW-1:0]    zb;
    logic [ZW-1:0]    zd;
    logic             sna;
    logic             cna;
    logic             snb;
    logic             cnb;
    logic             cnd;
    logic [NUM_W-1:0] num;
  } gcte_fe_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } gcte_xyz_t;

  // Arctangent table, Q30 radians.
  function automatic logic [30:0] atan_q30(input int i);
    logic [30:0] v;
    case (i)
      0:  v = 31'd843314857;
      1:  v = 31'd497837829;
      2:  v = 31'd263043837;
      3:  v = 31'd133525159;
      4:  v = 31'd67021687;
      5:  v = 31'd33543516;
      6:  v = 31'd16775851;
      7:  v = 31'd8388437;
      8:  v = 31'd4194283;
      9:  v = 31'd2097149;
      10: v = 31'd1048576;
      11: v = 31'd524288;
      12: v = 31'd262144;
      13: v = 31'd131072;
      14: v = 31'd65536;
      15: v = 31'd32768;
      16: v = 31'd16384;
      17: v = 31'd8192;
      18: v = 31'd4096;
      19: v = 31'd2048;
      20: v = 31'd1024;
      21: v = 31'd512;
      22: v = 31'd256;
      23: v = 31'd128;
      24: v = 31'd64;
      25: v = 31'd32;
      26: v = 31'd16;
      27: v = 31'd8;
      28: v = 31'd4;
      29: v = 31'd2;
      30: v = 31'd1;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

  // One rotation-mode CORDIC step; shifts are floor shifts.
  function automatic gcte_xyz_t rot_xyz(input gcte_xyz_t v, input int i);
    logic signed [CW-1:0] x, y, z, dx, dy, ang;
    gcte_xyz_t r;
    x   = v.x;
    y   = v.y;
    z   = v.z;
    dx  = y >>> i;
    dy  = x >>> i;
    ang = CW'(atan_q30(i));
    if (z >= 0) begin
      r.x = x - dx;
      r.y = y + dy;
      r.z = z - ang;
    end else begin
      r.x = x + dx;
      r.y = y - dy;
      r.z = z + ang;
    end
    return r;
  endfunction

  // One vectoring-mode CORDIC step, driving y toward zero.
  function automatic gcte_xyz_t vec_xyz(input gcte_xyz_t v, input int i);
    logic signed [CW-1:0] x, y, z, dx, dy, ang;
    gcte_xyz_t r;
    x   = v.x;
    y   = v.y;
    z   = v.z;
    dx  = y >>> i;
    dy  = x >>> i;
    ang = CW'(atan_q30(i));
    if (y >= 0) begin
      r.x = x + dx;
      r.y = y - dy;
      r.z = z + ang;
    end else begin
      r.x = x - dx;
      r.y = y + dy;
      r.z = z - ang;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/gcte_front.sv
`default_nettype none

module gcte_front import gcte_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_valid_i,
  output logic                 s_ready_o,
  input  wire logic [IN_W-1:0] s_data_i,
  output logic                 fe_valid_o,
  input  wire logic            fe_ready_i,
  output gcte_fe_t             fe_data_o
);

  typedef struct packed {
    logic [MW-1:0] m;
    logic          sn;
    logic          cn;
  } gcte_fold_t;

  // Reduce an angle difference into [-180, 180) degrees.
  function automatic logic signed [RW-1:0] reduce(input logic signed [RW-1:0] v);
    logic signed [RW-1:0] r;
    r = v;
    if (v >= FULL_DEG) begin
      r = v - FULL_DEG;
    end else if (v <= -FULL_DEG) begin
      r = v + FULL_DEG;
    end
    if (r >= HALF_DEG) begin
      r = r - FULL_DEG;
    end else if (r < -HALF_DEG) begin
      r = r + FULL_DEG;
    end
    return r;
  endfunction

  // Fold into the first quadrant and keep the signs of sine and cosine.
  function automatic gcte_fold_t fold(input logic signed [RW-1:0] r);
    logic signed [RW-1:0] a;
    gcte_fold_t f;
    a    = r[RW-1] ? -r : r;
    f.m  = a[MW-1:0];
    f.sn = r[RW-1];
    f.cn = 1'b0;
    if (f.m > QUART_MAG) begin
      f.m  = HALF_MAG - f.m;
      f.cn = 1'b1;
    end
    return f;
  endfunction

  function automatic logic [ZW-1:0] to_rad(input logic [MW-1:0] m);
    logic [50:0] p;
    p = 51'(m) * 51'(DEG2RAD_Q32);
    return p[RAD_SHIFT +: ZW];
  endfunction

  logic                 v1_q, v2_q, v3_q;
  logic                 adv;
  logic signed [RW-1:0] ra_q, rb_q, rd_q;
  logic [47:0]          prod_q;
  gcte_fold_t           fa_q, fb_q, fd_q;
  logic [NUM_W-1:0]     num_q;
  gcte_fe_t             fe_q;

  logic signed [23:0] lat_a, lat_b;
  logic signed [24:0] lon_a, lon_b;
  logic [23:0]        pop_a, pop_b;

  // Unpack the input beat.
  assign lat_a = s_data_i[23:0];
  assign lon_a = s_data_i[48:24];
  assign pop_a = s_data_i[72:49];
  assign lat_b = s_data_i[96:73];
  assign lon_b = s_data_i[121:97];
  assign pop_b = s_data_i[145:122];

  // The three stages move together; the last one holds while the queue is full.
  assign adv        = !v3_q || fe_ready_i;
  assign s_ready_o  = adv;
  assign fe_valid_o = v3_q;
  assign fe_data_o  = fe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Stage one reduces the angles and forms the population product, stage two
  // folds them, stage three converts degrees to Q30 radians.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ra_q   <= reduce(RW'(lat_a));
      rb_q   <= reduce(RW'(lat_b));
      rd_q   <= reduce(RW'(lon_a) - RW'(lon_b));
      prod_q <= 48'(pop_a) * 48'(pop_b);
      fa_q   <= fold(ra_q);
      fb_q   <= fold(rb_q);
      fd_q   <= fold(rd_q);
      num_q  <= prod_q[47:POP_SHIFT];
      fe_q.za  <= to_rad(fa_q.m);
      fe_q.zb  <= to_rad(fb_q.m);
      fe_q.zd  <= to_rad(fd_q.m);
      fe_q.sna <= fa_q.sn;
      fe_q.cna <= fa_q.cn;
      fe_q.snb <= fb_q.sn;
      fe_q.cnb <= fb_q.cn;
      fe_q.cnd <= fd_q.cn;
      fe_q.num <= num_q;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/gcte_fifo.sv
`default_nettype none

module gcte_fifo import gcte_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  gcte_fe_t      push_data_i,
  output logic          ready_o,
  input  wire logic     pop_i,
  output logic          valid_o,
  output gcte_fe_t      pop_data_o
);

  gcte_fe_t             mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wptr_q, rptr_q;
  logic [FIFO_AW:0]     cnt_q;
  logic                 do_push, do_pop;

  assign ready_o    = cnt_q != (FIFO_AW+1)'(FIFO_DEPTH);
  assign valid_o    = cnt_q != '0;
  assign pop_data_o = mem_q[rptr_q];
  assign do_push    = push_i && ready_o;
  assign do_pop     = pop_i && valid_o;

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      cnt_q <= cnt_q + (FIFO_AW+1)'(do_push) - (FIFO_AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/gcte_back.sv
`default_nettype none

module gcte_back import gcte_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             fe_valid_i,
  input  gcte_fe_t              fe_data_i,
  output logic                  fe_pop_o,
  input  wire logic [15:0]      radius_i,
  input  wire logic [13:0]      min_dist_i,
  output logic                  m_valid_o,
  input  wire logic             m_ready_i,
  output logic [OUT_W-1:0]      m_data_o
);

  localparam int ST_MUL1 = CORDIC_ITERS;
  localparam int ST_MUL2 = ST_MUL1 + 1;
  localparam int ST_ARG  = ST_MUL1 + 2;
  localparam int ST_SQ   = ST_MUL1 + 3;
  localparam int ST_SQRT = ST_MUL1 + 4;
  localparam int ST_VSET = ST_SQRT + SQRT_BITS;
  localparam int ST_VEC  = ST_VSET + 1;
  localparam int ST_DMUL = ST_VEC + CORDIC_ITERS;
  localparam int NST     = ST_DMUL + 1;

  typedef struct packed {
    gcte_xyz_t          a;
    gcte_xyz_t          b;
    gcte_xyz_t          d;
    logic               sna;
    logic               cna;
    logic               snb;
    logic               cnb;
    logic               cnd;
    logic signed [63:0] p1;
    logic signed [63:0] p2;
    logic signed [31:0] cd;
    logic signed [31:0] carg;
    logic [60:0]        rem;
    logic [30:0]        root;
    logic [40:0]        drem;
    logic [16:0]        quo;
    logic [47:0]        dprod;
  } gcte_pipe_t;

  function automatic gcte_pipe_t init_stage(input gcte_fe_t f);
    gcte_pipe_t r;
    r      = '0;
    r.a.x  = GAIN_Q30;
    r.b.x  = GAIN_Q30;
    r.d.x  = GAIN_Q30;
    r.a.z  = CW'(f.za);
    r.b.z  = CW'(f.zb);
    r.d.z  = CW'(f.zd);
    r.sna  = f.sna;
    r.cna  = f.cna;
    r.snb  = f.snb;
    r.cnb  = f.cnb;
    r.cnd  = f.cnd;
    r.drem = 41'(f.num);
    return r;
  endfunction

  function automatic gcte_pipe_t rot_stage(input gcte_pipe_t p, input int i);
    gcte_pipe_t r;
    r   = p;
    r.a = rot_xyz(p.a, i);
    r.b = rot_xyz(p.b, i);
    r.d = rot_xyz(p.d, i);
    return r;
  endfunction

  function automatic logic signed [31:0] sgn(input logic signed [CW-1:0] v,
                                             input logic neg);
    logic signed [CW-1:0] t;
    t = neg ? -v : v;
    return t[31:0];
  endfunction

  // sin(a)sin(b) and cos(a)cos(b).
  function automatic gcte_pipe_t mul1_stage(input gcte_pipe_t p);
    logic signed [31:0] sa, sb, ca, cb;
    gcte_pipe_t r;
    r    = p;
    sa   = sgn(p.a.y, p.sna);
    sb   = sgn(p.b.y, p.snb);
    ca   = sgn(p.a.x, p.cna);
    cb   = sgn(p.b.x, p.cnb);
    r.cd = sgn(p.d.x, p.cnd);
    r.p1 = sa * sb;
    r.p2 = ca * cb;
    return r;
  endfunction

  // cos(a)cos(b) back to Q30, then times cos(dlon).
  function automatic gcte_pipe_t mul2_stage(input gcte_pipe_t p);
    logic signed [63:0] v, t;
    logic signed [31:0] t32, c;
    gcte_pipe_t r;
    r    = p;
    v    = p.p2;
    t    = v >>> 30;
    t32  = t[31:0];
    c    = p.cd;
    r.p2 = t32 * c;
    return r;
  endfunction

  // Sum, back to Q30, clamp to [-1, 1].
  function automatic gcte_pipe_t arg_stage(input gcte_pipe_t p);
    logic signed [63:0] u, w, s;
    gcte_pipe_t r;
    r = p;
    u = p.p1;
    w = p.p2;
    s = (u + w) >>> 30;
    if (s > 64'sd1073741824) begin
      s = 64'sd1073741824;
    end else if (s < -64'sd1073741824) begin
      s = -64'sd1073741824;
    end
    r.carg = s[31:0];
    return r;
  endfunction

  // Radicand 2^60 - c^2 for the sine of the angle.
  function automatic gcte_pipe_t sq_stage(input gcte_pipe_t p);
    logic signed [31:0] c, mag;
    logic [61:0]        sq, n;
    gcte_pipe_t r;
    r      = p;
    c      = p.carg;
    mag    = c[31] ? -c : c;
    sq     = 62'(mag[30:0]) * 62'(mag[30:0]);
    n      = (62'd1 << 60) - sq;
    r.rem  = n[60:0];
    r.root = '0;
    return r;
  endfunction

  // One root bit per stage; the first stages also retire one quotient bit.
  function automatic gcte_pipe_t sqrt_stage(input gcte_pipe_t p, input int k,
                                            input int dk);
    logic [61:0] t;
    logic [40:0] dv;
    gcte_pipe_t r;
    r = p;
    t = (62'(p.root) << (k + 1)) | (62'd1 << (2 * k));
    if ({1'b0, p.rem} >= t) begin
      r.rem     = p.rem - t[60:0];
      r.root[k] = 1'b1;
    end
    if (dk >= 0) begin
      dv = DIV_D << dk;
      if (p.drem >= dv) begin
        r.drem    = p.drem - dv;
        r.quo[dk] = 1'b1;
      end
    end
    return r;
  endfunction

  // Start vector for the arccos, turned by 90 degrees when c is negative.
  function automatic gcte_pipe_t vset_stage(input gcte_pipe_t p);
    logic signed [31:0]   c;
    logic signed [CW-1:0] cx, sx;
    gcte_pipe_t r;
    r  = p;
    c  = p.carg;
    cx = CW'(c);
    sx = CW'(p.root);
    if (c[31]) begin
      r.a.x = sx;
      r.a.y = -cx;
      r.a.z = HALF_PI_Q30;
    end else begin
      r.a.x = cx;
      r.a.y = sx;
      r.a.z = '0;
    end
    return r;
  endfunction

  function automatic gcte_pipe_t vec_stage(input gcte_pipe_t p, input int i);
    gcte_pipe_t r;
    r   = p;
    r.a = vec_xyz(p.a, i);
    return r;
  endfunction

  // Angle times radius; a negative angle counts as zero.
  function automatic gcte_pipe_t dmul_stage(input gcte_pipe_t p,
                                            input logic [15:0] rad);
    logic signed [CW-1:0] z;
    logic [31:0]          ang;
    gcte_pipe_t r;
    r       = p;
    z       = p.a.z;
    ang     = z[CW-1] ? 32'd0 : z[31:0];
    r.dprod = 48'(ang) * 48'(rad);
    return r;
  endfunction

  gcte_pipe_t       st_q [NST];
  gcte_pipe_t       st_d [NST];
  logic [NST-1:0]   vld_q;
  logic             adv;
  logic             out_v_q;
  logic [15:0]      dist_q;
  logic [16:0]      traffic_q;
  logic [17:0]      dist_raw;
  logic [15:0]      dist_sat;

  // The whole pipeline advances unless a finished beat is waiting.
  assign adv      = !out_v_q || m_ready_i;
  assign fe_pop_o = adv && fe_valid_i;

  // Stage functions, one per pipeline register.
  for (genvar k = 0; k < CORDIC_ITERS; k++) begin : g_rot
    if (k == 0) begin : g_first
      assign st_d[k] = rot_stage(init_stage(fe_data_i), k);
    end else begin : g_next
      assign st_d[k] = rot_stage(st_q[k-1], k);
    end
  end

  assign st_d[ST_MUL1] = mul1_stage(st_q[ST_MUL1-1]);
  assign st_d[ST_MUL2] = mul2_stage(st_q[ST_MUL2-1]);
  assign st_d[ST_ARG]  = arg_stage(st_q[ST_ARG-1]);
  assign st_d[ST_SQ]   = sq_stage(st_q[ST_SQ-1]);

  for (genvar j = 0; j < SQRT_BITS; j++) begin : g_sqrt
    assign st_d[ST_SQRT+j] = sqrt_stage(st_q[ST_SQRT+j-1], SQRT_BITS - 1 - j,
                                        (j < DIV_BITS) ? DIV_BITS - 1 - j : -1);
  end

  assign st_d[ST_VSET] = vset_stage(st_q[ST_VSET-1]);

  for (genvar k = 0; k < CORDIC_ITERS; k++) begin : g_vec
    assign st_d[ST_VEC+k] = vec_stage(st_q[ST_VEC+k-1], k);
  end

  assign st_d[ST_DMUL] = dmul_stage(st_q[ST_DMUL-1], radius_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-2:0], fe_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NST; k++) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  // Output register: saturate the distance and gate the traffic estimate.
  assign dist_raw = st_q[ST_DMUL].dprod[47:30];
  assign dist_sat = (dist_raw[17:16] != 2'b00) ? 16'hFFFF : dist_raw[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= vld_q[NST-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dist_q    <= dist_sat;
      traffic_q <= (dist_sat < 16'(min_dist_i)) ? 17'd0 : st_q[ST_DMUL].quo;
    end
  end

  assign m_valid_o = out_v_q;
  assign m_data_o  = {7'd0, traffic_q, dist_q};

endmodule

`default_nettype wire

// File: rtl/core/great_circle_traffic_estimate.sv
// Great-circle distance and traffic estimate for a stream of point pairs.
// Input stream (s_axis): one beat carries both points, each a latitude, a
// longitude (signed degrees in Q16) and a population. Output stream (m_axis):
// one beat per input beat, in order, with the distance in whole miles and the
// population product over 2.5e9, forced to zero below the minimum distance.
// The APB port holds min_distance (offset 0) and radius_miles (offset 4); it
// should be written only while no beat is in flight.
// Throughput is one beat per cycle while the receiver accepts. A beat
// passes through 90 register stages, the first loaded at the accepting
// edge: three front stages reduce, fold and convert the angles, one queue
// entry, then 24 sine/cosine CORDIC stages, two multiply stages, a clamp
// stage, a square stage, 31 square-root stages (which also hold the
// 17-step division), a start-vector stage, a 24-stage arccos CORDIC, the
// radius multiply and the output register.
// When the receiver stalls, the back pipeline holds, the queue fills, and then
// s_axis_tready drops. Reset empties the pipeline and the queue and loads the
// registers with 100 miles and a radius of 3963 miles.
`default_nettype none

module great_circle_traffic_estimate import gcte_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  // lat_a[23:0], lon_a[48:24], pop_a[72:49], lat_b[96:73], lon_b[121:97],
  // pop_b[145:122], zero fill to 151
  input  wire logic [IN_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // distance_miles[15:0], traffic[32:16], zero fill to 39
  output logic [OUT_W-1:0]      m_axis_tdata,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [13:0] min_dist_q;
  logic [15:0] radius_q;
  logic        fe_valid, fe_ready, q_valid, q_pop;
  gcte_fe_t    fe_data, q_data;

  // Configuration registers.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_dist_q <= MIN_DIST_RST;
      radius_q   <= RADIUS_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_MIN_DIST: min_dist_q <= pwdata[13:0];
        REG_RADIUS:   radius_q   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MIN_DIST: prdata = {18'd0, min_dist_q};
      REG_RADIUS:   prdata = {16'd0, radius_q};
      default:      prdata = '0;
    endcase
  end

  gcte_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .s_data_i   (s_axis_tdata),
    .fe_valid_o (fe_valid),
    .fe_ready_i (fe_ready),
    .fe_data_o  (fe_data)
  );

  gcte_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fe_valid),
    .push_data_i (fe_data),
    .ready_o     (fe_ready),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_data)
  );

  gcte_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fe_valid_i (q_valid),
    .fe_data_i  (q_data),
    .fe_pop_o   (q_pop),
    .radius_i   (radius_q),
    .min_dist_i (min_dist_q),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_data_o   (m_axis_tdata)
  );

endmodule

`default_nettype wire

// File: rtl/core/gcte_checker.sv
`default_nettype none

module gcte_checker import gcte_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             s_axis_tvalid,
  input wire logic             s_axis_tready,
  input wire logic [IN_W-1:0]  s_axis_tdata,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready,
  input wire logic [OUT_W-1:0] m_axis_tdata,
  input wire logic             psel,
  input wire logic             penable,
  input wire logic             pwrite,
  input wire logic [2:0]       paddr,
  input wire logic [31:0]      pwdata,
  input wire logic [31:0]      prdata,
  input wire logic             pready
);

  // A stalled result beat keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // The traffic quotient never exceeds the largest 48-bit product over 2.5e9.
  a_traffic_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[32:16] <= 17'd112589) && (m_axis_tdata[39:33] == 7'd0))
    else $error("traffic out of range");

  // A written minimum distance reads back in the next cycle.
  a_min_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(psel && penable && pwrite && pready && !paddr[2]) && psel && !pwrite &&
    !paddr[2] |-> prdata[13:0] == $past(pwdata[13:0]))
    else $error("minimum distance readback mismatch");

  // A written radius reads back in the next cycle.
  a_radius_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(psel && penable && pwrite && pready && paddr[2]) && psel && !pwrite &&
    paddr[2] |-> prdata[15:0] == $past(pwdata[15:0]))
    else $error("radius readback mismatch");

endmodule

bind great_circle_traffic_estimate gcte_checker u_gcte_checker (.*);

`default_nettype wire
